@@ rtl/core/lfu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned STAMP_W = 64;
    localparam int unsigned CAP_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register index of the capacity register on the configuration port.
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } lfu_state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } lfu_entry_t;

    localparam int unsigned ENTRY_W = $bits(lfu_entry_t);

endpackage

`default_nettype wire

@@ rtl/core/lfu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/lfu_cache_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                Payload
// in       in_valid / in_ready      kind, lookup_key, write_value
// out      out_valid / out_ready    found, read_value
// cfg      psel, penable, pwrite    paddr, pwdata, prdata, pready
//
// From accept to the next accept, an item passes through the accept, one entry read
// per resident entry, a pass over the last registered read, and an update.
// A put with capacity zero is dropped in the cycle it is accepted.
// Reset clears occupancy, the access clock and all control state; no clearing pass is run.
// A get result waits in the output register while the next item is accepted; a later get
// holds in its update cycle until that register is free.

module lfu_cache_table_top
    import lfu_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                kind,
    input  wire logic signed [31:0]  lookup_key,
    input  wire logic signed [31:0]  write_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     found,
    output logic signed [31:0]       read_value,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    lfu_state_t         state_reg, state_next;
    logic               kind_reg, kind_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VALUE_W-1:0] wval_reg, wval_next;
    logic [OCC_W-1:0]   issue_idx_reg, issue_idx_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [VALUE_W-1:0] hit_value_reg, hit_value_next;
    logic [COUNT_W-1:0] hit_count_reg, hit_count_next;
    logic               best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [COUNT_W-1:0] best_count_reg, best_count_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [CAP_W-1:0]   capacity_reg, capacity_next;
    logic               out_valid_reg, out_valid_next;
    logic               found_reg, found_next;
    logic [VALUE_W-1:0] read_value_reg, read_value_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    lfu_entry_t         ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    lfu_entry_t         rd_entry;

    logic [CMP_W-1:0]   cap_raw;
    logic [CMP_W-1:0]   cap_eff;
    logic [STAMP_W-1:0] stamp_new;
    logic [COUNT_W-1:0] hit_count_inc;
    logic               issue;
    logic               cfg_write;

    lfu_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_entry  = lfu_entry_t'(ram_rdata);
    assign cap_raw   = CMP_W'(capacity_reg);
    assign cap_eff   = (cap_raw > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_raw;
    assign stamp_new = clock_reg + STAMP_W'(1);
    assign hit_count_inc = (hit_count_reg == COUNT_MAX) ? hit_count_reg
                                                        : hit_count_reg + COUNT_W'(1);
    assign issue     = (issue_idx_reg < occ_reg);

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity_reg}
                                                  : 32'd0;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        wval_next       = wval_reg;
        issue_idx_next  = issue_idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_value_next  = hit_value_reg;
        hit_count_next  = hit_count_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_count_next = best_count_reg;
        best_stamp_next = best_stamp_reg;
        clock_next      = clock_reg;
        occ_next        = occ_reg;
        capacity_next   = capacity_reg;
        out_valid_next  = out_valid_reg;
        found_next      = found_reg;
        read_value_next = read_value_reg;

        ram_we    = 1'b0;
        ram_waddr = hit_idx_reg;
        ram_wdata = '{key: key_reg, value: hit_value_reg, count: hit_count_inc,
                      stamp: stamp_new};
        ram_re    = 1'b0;
        ram_raddr = issue_idx_reg[IDX_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write && paddr[2] == REG_CAPACITY)
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next      = kind;
                    key_next       = lookup_key;
                    wval_next      = write_value;
                    issue_idx_next = '0;
                    hit_found_next = 1'b0;
                    best_vld_next  = 1'b0;
                    // A put is dropped when the cache may hold nothing.
                    if (!(kind && cap_eff == '0))
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                ram_re      = issue;
                rd_vld_next = issue;
                rd_idx_next = issue_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    issue_idx_next = issue_idx_reg + OCC_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (!hit_found_reg && rd_entry.key == key_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_value_next = rd_entry.value;
                        hit_count_next = rd_entry.count;
                    end
                    if (!best_vld_reg || rd_entry.count < best_count_reg ||
                        (rd_entry.count == best_count_reg && rd_entry.stamp < best_stamp_reg))
                    begin
                        best_vld_next   = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_count_next = rd_entry.count;
                        best_stamp_next = rd_entry.stamp;
                    end
                end
                if (!issue)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                if (!kind_reg)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_next  = 1'b1;
                        found_next      = hit_found_reg;
                        read_value_next = hit_found_reg ? hit_value_reg : '0;
                        if (hit_found_reg)
                        begin
                            ram_we     = 1'b1;
                            clock_next = stamp_new;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    clock_next = stamp_new;
                    if (hit_found_reg)
                    begin
                        ram_wdata.value = wval_reg;
                    end
                    else
                    begin
                        ram_wdata.value = wval_reg;
                        ram_wdata.count = COUNT_W'(1);
                        if (CMP_W'(occ_reg) >= cap_eff)
                        begin
                            ram_waddr = best_idx_reg;
                        end
                        else
                        begin
                            ram_waddr = occ_reg[IDX_W-1:0];
                            occ_next  = occ_reg + OCC_W'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            clock_reg     <= '0;
            occ_reg       <= '0;
            capacity_reg  <= CAP_W'(16);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            clock_reg     <= clock_next;
            occ_reg       <= occ_next;
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        wval_reg       <= wval_next;
        issue_idx_reg  <= issue_idx_next;
        rd_idx_reg     <= rd_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_value_reg  <= hit_value_next;
        hit_count_reg  <= hit_count_next;
        best_vld_reg   <= best_vld_next;
        best_idx_reg   <= best_idx_next;
        best_count_reg <= best_count_next;
        best_stamp_reg <= best_stamp_next;
        found_reg      <= found_next;
        read_value_reg <= read_value_next;
    end

endmodule

`default_nettype wire

@@ verif/lfu_cache_table_top_tb.sv @@
`timescale 1ns / 1ps

module lfu_cache_table_top_tb;
    import lfu_pkg::*;

    localparam int NUM_ENTRIES = 16;
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;
    localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int POOL_SIZE = 32;
    localparam int OP_SLOTS = 1024;

    typedef struct {
        logic        op;
        logic [31:0] key;
        logic [31:0] value;
    } cache_op_t;

    typedef struct {
        logic        hit;
        logic [31:0] data;
    } lookup_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic [31:0] lookup_key = '0;
    logic [31:0] write_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic found;
    logic [31:0] read_value;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    cache_op_t pending_ops [OP_SLOTS];
    lookup_result_t expected_lookups [OP_SLOTS];
    cache_op_t next_op;
    lookup_result_t oldest_lookup;

    logic               cached_valid [NUM_ENTRIES];
    logic [KEY_W-1:0]   cached_key   [NUM_ENTRIES];
    logic [VALUE_W-1:0] cached_value [NUM_ENTRIES];
    logic [COUNT_W-1:0] cached_count [NUM_ENTRIES];
    logic [STAMP_W-1:0] cached_stamp [NUM_ENTRIES];
    logic [STAMP_W-1:0] model_clock = '0;
    int                 model_fill = 0;
    logic [CAP_W-1:0]   model_capacity = 5'd16;

    logic [31:0] key_pool [POOL_SIZE];
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int ops_queued = 0;
    int ops_sent = 0;
    int ops_accepted = 0;
    int lookups_expected = 0;
    int lookups_checked = 0;
    int hits_seen = 0;
    int cfg_writes = 0;
    int mismatches = 0;

    lfu_cache_table_top #(
        .ENTRIES(NUM_ENTRIES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .lookup_key(lookup_key),
        .write_value(write_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .found(found),
        .read_value(read_value),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int lookup_slot(input logic [KEY_W-1:0] key);
        int i;
        for (i = 0; i < NUM_ENTRIES; i++)
            if (cached_valid[i] && cached_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int pick_evict_slot();
        int i;
        int best;
        best = -1;
        for (i = 0; i < NUM_ENTRIES; i++)
        begin
            if (!cached_valid[i])
                continue;
            if (best < 0 || cached_count[i] < cached_count[best] ||
                (cached_count[i] == cached_count[best] && cached_stamp[i] < cached_stamp[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic int first_free_slot();
        int i;
        for (i = 0; i < NUM_ENTRIES; i++)
            if (!cached_valid[i])
                return i;
        return -1;
    endfunction

    task automatic bump_use(input int i);
        if (cached_count[i] != COUNT_MAX)
            cached_count[i]++;
        model_clock++;
        cached_stamp[i] = model_clock;
    endtask

    task automatic expect_lookup(input logic hit, input logic [31:0] data);
        expected_lookups[lookups_expected % OP_SLOTS] = '{hit, data};
        lookups_expected++;
    endtask

    task automatic lfu_apply_op(input logic op, input logic [31:0] key, input logic [31:0] val);
        int cap;
        int hit;
        int slot;
        cap = (model_capacity > NUM_ENTRIES) ? NUM_ENTRIES : int'(model_capacity);
        hit = lookup_slot(key);
        if (op == OP_GET)
        begin
            if (hit >= 0)
            begin
                bump_use(hit);
                expect_lookup(1'b1, cached_value[hit]);
            end
            else
            begin
                expect_lookup(1'b0, 32'd0);
            end
        end
        else if (cap != 0)
        begin
            if (hit >= 0)
            begin
                cached_value[hit] = val;
                bump_use(hit);
            end
            else
            begin
                slot = (model_fill >= cap) ? pick_evict_slot() : first_free_slot();
                if (slot < 0)
                    slot = pick_evict_slot();
                if (slot >= 0)
                begin
                    if (!cached_valid[slot])
                        model_fill++;
                    cached_valid[slot] = 1'b1;
                    cached_key[slot] = key;
                    cached_value[slot] = val;
                    cached_count[slot] = 1;
                    model_clock++;
                    cached_stamp[slot] = model_clock;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                lfu_apply_op(kind, lookup_key, write_value);
                ops_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (ops_sent != ops_queued && $urandom_range(99) >= src_idle_pct)
                begin
                    next_op = pending_ops[ops_sent % OP_SLOTS];
                    ops_sent++;
                    in_valid <= 1'b1;
                    kind <= next_op.op;
                    lookup_key <= next_op.key;
                    write_value <= next_op.value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (lookups_expected == lookups_checked)
                begin
                    report_mismatch("lookup result with no lookup outstanding");
                end
                else
                begin
                    oldest_lookup = expected_lookups[lookups_checked % OP_SLOTS];
                    lookups_checked++;
                    if (oldest_lookup.hit)
                        hits_seen++;
                    if (found !== oldest_lookup.hit)
                        report_mismatch($sformatf("lookup %0d: found %b, expected %b",
                            lookups_checked, found, oldest_lookup.hit));
                    if (read_value !== oldest_lookup.data)
                        report_mismatch($sformatf("lookup %0d: read_value %h, expected %h",
                            lookups_checked, read_value, oldest_lookup.data));
                end
            end
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic cfg_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= CAP_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_capacity(input int cap);
        logic [31:0] wdata;
        logic [31:0] rdata;
        wdata = $urandom;
        wdata[CAP_W-1:0] = cap[CAP_W-1:0];
        cfg_access(1'b1, wdata, rdata);
        model_capacity = cap[CAP_W-1:0];
        cfg_writes++;
        cfg_access(1'b0, 32'd0, rdata);
        if (rdata !== {27'd0, model_capacity})
            report_mismatch($sformatf("capacity reads back %h, expected %h", rdata, model_capacity));
    endtask

    task automatic queue_op(input logic op, input logic [31:0] key, input logic [31:0] val);
        pending_ops[ops_queued % OP_SLOTS] = '{op, key, val};
        ops_queued++;
    endtask

    task automatic queue_random_op(input int pool_n);
        logic [31:0] key;
        key = ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(pool_n - 1)];
        queue_op($urandom_range(1) ? OP_PUT : OP_GET, key, $urandom);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((ops_accepted != ops_queued || lookups_expected != lookups_checked) &&
               guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT)
            report_mismatch($sformatf("%0d items unaccepted, %0d lookups outstanding",
                ops_queued - ops_accepted, lookups_expected - lookups_checked));
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int cap, input int src_pct, input int sink_pct,
                             input int n_ops, input int pool_n, input int chunk);
        int i;
        write_capacity(cap);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (i = 0; i < n_ops; i++)
        begin
            queue_random_op(pool_n);
            if (chunk != 0 && (i + 1) % chunk == 0)
                wait_idle();
        end
        wait_idle();
    endtask

    initial
    begin
        #2000000;
        $display("** lfu_cache_table_top: FAILED **");
        $finish;
    end

    initial
    begin
        logic [31:0] rdata;
        int i;
        for (i = 0; i < NUM_ENTRIES; i++)
            cached_valid[i] = 1'b0;
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'h0000_0000;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_access(1'b0, 32'd0, rdata);
        if (rdata !== 32'd16)
            report_mismatch($sformatf("capacity after reset reads %h", rdata));

        queue_op(OP_GET, 32'h0000_0000, 32'h1234_5678);
        queue_op(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_op(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_op(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        wait_idle();

        // Three entries are resident, so this capacity starts below occupancy.
        write_capacity(2);
        queue_op(OP_PUT, 32'd1, 32'd11);
        queue_op(OP_GET, 32'h8000_0000, 32'd0);
        queue_op(OP_GET, 32'd1, 32'd0);
        queue_op(OP_PUT, 32'd2, 32'd22);
        queue_op(OP_GET, 32'd1, 32'd0);
        queue_op(OP_GET, 32'd2, 32'd0);
        queue_op(OP_GET, 32'd2, 32'd0);
        queue_op(OP_PUT, 32'd3, 32'd33);
        queue_op(OP_GET, 32'd1, 32'd0);
        queue_op(OP_GET, 32'd2, 32'd0);
        queue_op(OP_GET, 32'd3, 32'd0);
        wait_idle();

        write_capacity(0);
        queue_op(OP_PUT, 32'd5, 32'd55);
        queue_op(OP_GET, 32'd5, 32'd0);
        queue_op(OP_GET, 32'd2, 32'd0);
        wait_idle();

        run_phase(31, 0, 0, 90, 24, 0);
        run_phase(4, 87, 0, 90, 8, 0);
        run_phase(16, 0, 87, 90, 24, 0);
        run_phase(1, 20, 20, 60, 3, 15);
        run_phase(0, 20, 20, 30, 24, 0);
        run_phase(9, 0, 0, 90, 14, 30);

        $display("Covered %0d cache items across %0d capacity settings from zero to above table size,",
            ops_accepted, cfg_writes);
        $display("with %0d lookups checked (%0d hits) under mixed idle and stall patterns.",
            lookups_checked, hits_seen);
        if (mismatches == 0)
            $display("** lfu_cache_table_top: PASSED **");
        else
            $display("** lfu_cache_table_top: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/lfu_pkg.sv
rtl/core/lfu_ram.sv
rtl/core/lfu_cache_table_top.sv
verif/lfu_cache_table_top_tb.sv
